// ===== src/cell_type_map_with_slot_allocator_unit_defines.svh =====
// Assertion macros used by the checker of the cell type map unit.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CELL_TYPE_MAP_WITH_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define CELL_TYPE_MAP_WITH_SLOT_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define CTSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CTSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ctsa_pkg.sv =====
// Shared types, constants and helpers for the cell type map unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctsa_pkg;

  localparam int AXIS_BITS   = 5;
  localparam int SLOT_COUNT  = 1024;
  localparam int HANDLE_BITS = 16;

  localparam int CELL_BITS  = 3 * AXIS_BITS;
  localparam int GRID_CELLS = 1 << CELL_BITS;
  localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
  localparam int TBL_W      = 11;
  localparam int CODE_W     = 11;
  localparam int TYPE_W     = 4;
  localparam int CNT_W      = 16;
  localparam int SIZE_W     = 6;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  localparam logic signed [CODE_W-1:0] CODE_SOLID = -11'sd1;
  localparam logic signed [CODE_W-1:0] CODE_FLUID = -11'sd2;
  localparam logic signed [CODE_W-1:0] CODE_CF    = -11'sd3;
  localparam logic signed [CODE_W-1:0] CODE_FC    = -11'sd4;
  localparam logic signed [CODE_W-1:0] CODE_UNDEF = -11'sd5;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_ATTACH = 2'd1,
    OP_SET    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    CLS_SOLID,
    CLS_FLUID,
    CLS_IFACE,
    CLS_SLOT,
    CLS_UNDEF
  } cls_t;

  // class counter update for one committed cell write
  typedef struct packed {
    logic en;
    cls_t old_cls;
    cls_t new_cls;
  } cnt_upd_t;

  typedef struct packed {
    logic [CNT_W-1:0] solid;
    logic [CNT_W-1:0] plain;
    logic [CNT_W-1:0] iface;
    logic [CNT_W-1:0] slot;
    logic [CNT_W-1:0] undef;
  } cnt_set_t;

  function automatic cls_t code_class(input logic signed [CODE_W-1:0] code);
    cls_t c;
    if (!code[CODE_W-1]) c = CLS_SLOT;
    else if (code == CODE_SOLID) c = CLS_SOLID;
    else if (code == CODE_FLUID) c = CLS_FLUID;
    else if (code inside {CODE_CF, CODE_FC}) c = CLS_IFACE;
    else c = CLS_UNDEF;
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/cell_type_map_with_slot_allocator_unit.sv =====
// Top level of the cell type map with condition slot allocator.
// Depends on ctsa_pkg, ctsa_ram, ctsa_cfg and ctsa_stats.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake               Carries
// in_*      in   in_valid / in_ready     request word: op, coordinates, handle, type
// out_*     out  out_valid / out_ready   result word: status, cell content, counts
// p*        in   psel+penable+pwrite     grid size registers, pready tied high
//
// Each request word passes through accept (cell map and free stack top read),
// slot table read addressed by the cell content, then commit of all writes.
// The slot table read depends on the cell map read; a new word is taken after commit.
// After reset a clearing pass writes undefined into all 32768 cells of the map
// with in_ready low; configuration writes are taken meanwhile.
// The result register holds one finished word; commit waits only while it
// is still full and out_ready is low.

module cell_type_map_with_slot_allocator_unit
  import ctsa_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // request channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               in_op,
  input  wire logic [AXIS_BITS-1:0]     in_coord_x,
  input  wire logic [AXIS_BITS-1:0]     in_coord_y,
  input  wire logic [AXIS_BITS-1:0]     in_coord_z,
  input  wire logic [HANDLE_BITS-1:0]   in_cond_handle,
  input  wire logic signed [TYPE_W-1:0] in_type_code,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [1:0]                    out_status,
  output logic signed [CODE_W-1:0]      out_cell_code,
  output logic [HANDLE_BITS-1:0]        out_cell_cond,
  output logic [CNT_W-1:0]              out_solid_total,
  output logic [CNT_W-1:0]              out_fluid_total,
  output logic [CNT_W-1:0]              out_plain_fluid_total,
  output logic [CNT_W-1:0]              out_slot_cell_total,
  output logic [CNT_W-1:0]              out_undefined_total,
  output logic [TBL_W-1:0]              out_table_size,
  output logic [TBL_W-1:0]              out_free_slots,
  // configuration port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_AW-1:0]        paddr,
  input  wire logic [CFG_DW-1:0]        pwdata,
  output logic [CFG_DW-1:0]             prdata,
  output logic                          pready
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_EXEC} state_t;

  localparam logic [TBL_W-1:0] SLOTS_MAX = TBL_W'(SLOT_COUNT);

  state_t state_r;

  // size registers
  logic [SIZE_W-1:0] size_x, size_y, size_z;

  // clearing pass
  logic [CELL_BITS-1:0] clr_idx_r;

  // request held from accept to commit
  op_t                  op_r;
  logic                 oor_r;
  logic [CELL_BITS-1:0] cell_addr_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic [TYPE_W-1:0]    tcode_r;

  // allocator state
  logic [TBL_W-1:0] alloc_r, alloc_nxt;
  logic [TBL_W-1:0] depth_r, depth_nxt;

  // result register
  logic                   out_valid_r;
  status_t                out_status_r;
  logic [CODE_W-1:0]      out_code_r;
  logic [HANDLE_BITS-1:0] out_cond_r;
  cnt_set_t               out_cnt_r;
  logic [CNT_W-1:0]       out_fluid_r;
  logic [TBL_W-1:0]       out_table_r;
  logic [TBL_W-1:0]       out_free_r;

  // memory ports
  logic                   cell_we, cell_re;
  logic [CELL_BITS-1:0]   cell_waddr;
  logic [CODE_W-1:0]      cell_wdata, cell_rd;
  logic                   hdl_we, hdl_re;
  logic [SLOT_BITS-1:0]   hdl_waddr;
  logic [HANDLE_BITS-1:0] hdl_rd;
  logic                   stk_we, stk_re;
  logic [SLOT_BITS-1:0]   stk_raddr;
  logic [SLOT_BITS-1:0]   stk_rd;

  logic     accept, commit;
  cnt_upd_t upd;
  cnt_set_t cnt_nxt;

  // exec-stage results
  status_t                res_status;
  logic [CODE_W-1:0]      res_code;
  logic [HANDLE_BITS-1:0] res_cond;
  logic [CODE_W-1:0]      tc_ext, set_code;
  logic [SLOT_BITS-1:0]   new_slot;
  logic                   cur_slot;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  ctsa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size_x  (size_x),
    .size_y  (size_y),
    .size_z  (size_z)
  );

  // cell codes: negative type or slot index
  ctsa_ram #(.WIDTH(CODE_W), .DEPTH(GRID_CELLS)) u_cell_map (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (cell_re),
    .raddr ({in_coord_z, in_coord_y, in_coord_x}),
    .rdata (cell_rd)
  );

  // handle per slot
  ctsa_ram #(.WIDTH(HANDLE_BITS), .DEPTH(SLOT_COUNT)) u_slot_hdl (
    .clk   (clk),
    .we    (hdl_we),
    .waddr (hdl_waddr),
    .wdata (handle_r),
    .re    (hdl_re),
    .raddr (cell_rd[SLOT_BITS-1:0]),
    .rdata (hdl_rd)
  );

  // LIFO of released slots
  ctsa_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOT_COUNT)) u_free_stk (
    .clk   (clk),
    .we    (stk_we),
    .waddr (depth_r[SLOT_BITS-1:0]),
    .wdata (cell_rd[SLOT_BITS-1:0]),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rd)
  );

  ctsa_stats u_stats (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (upd),
    .cnt_nxt (cnt_nxt)
  );

  // reads: cell and stack top at accept, slot handle once the cell is known
  assign cell_re   = accept;
  assign stk_re    = accept;
  assign stk_raddr = SLOT_BITS'(depth_r - 1'b1);
  assign hdl_re    = (state_r == S_LOOK);

  assign cur_slot = !cell_rd[CODE_W-1];
  assign tc_ext   = {{(CODE_W-TYPE_W){tcode_r[TYPE_W-1]}}, tcode_r};
  assign set_code = (tc_ext inside {CODE_SOLID, CODE_FLUID, CODE_CF, CODE_FC}) ?
                    tc_ext : CODE_UNDEF;
  // reuse the top of the free stack before growing the table
  assign new_slot = (depth_r != '0) ? stk_rd : alloc_r[SLOT_BITS-1:0];

  always_comb begin
    cell_we     = 1'b0;
    cell_waddr  = cell_addr_r;
    cell_wdata  = cell_rd;
    hdl_we      = 1'b0;
    hdl_waddr   = cell_rd[SLOT_BITS-1:0];
    stk_we      = 1'b0;
    alloc_nxt   = alloc_r;
    depth_nxt   = depth_r;
    upd.en      = 1'b0;
    upd.old_cls = code_class(cell_rd);
    upd.new_cls = code_class(cell_rd);
    res_status  = ST_OK;
    res_code    = cell_rd;
    res_cond    = '0;

    if (state_r == S_CLEAR) begin
      cell_we    = 1'b1;
      cell_waddr = clr_idx_r;
      cell_wdata = CODE_UNDEF;
    end else if (state_r == S_EXEC) begin
      if (oor_r) begin
        res_status = ST_RANGE;
        res_code   = '0;
      end else begin
        case (op_r)
          OP_ATTACH: begin
            if (cur_slot) begin
              // cell keeps its slot, only the handle is rewritten
              hdl_we   = commit;
              res_cond = handle_r;
            end else if (depth_r == '0 && alloc_r >= SLOTS_MAX) begin
              res_status = ST_FULL;
            end else begin
              hdl_we      = commit;
              hdl_waddr   = new_slot;
              cell_we     = commit;
              cell_wdata  = CODE_W'(new_slot);
              upd.en      = commit;
              upd.new_cls = CLS_SLOT;
              if (depth_r != '0) begin
                depth_nxt = depth_r - 1'b1;
              end else begin
                alloc_nxt = alloc_r + 1'b1;
              end
              res_code = CODE_W'(new_slot);
              res_cond = handle_r;
            end
          end
          OP_SET: begin
            if (cur_slot && depth_r < SLOTS_MAX) begin
              stk_we    = commit;
              depth_nxt = depth_r + 1'b1;
            end
            cell_we     = commit;
            cell_wdata  = set_code;
            upd.en      = commit;
            upd.new_cls = code_class(set_code);
            res_code    = set_code;
          end
          default: begin
            if (cur_slot) begin
              res_cond = hdl_rd;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      alloc_r     <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (&clr_idx_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (commit) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (commit) begin
        alloc_r     <= alloc_nxt;
        depth_r     <= depth_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end

    // request payload, no reset needed
    if (accept) begin
      op_r        <= op_t'(in_op);
      cell_addr_r <= {in_coord_z, in_coord_y, in_coord_x};
      handle_r    <= in_cond_handle;
      tcode_r     <= in_type_code;
      oor_r       <= ({1'b0, in_coord_x} >= size_x) ||
                     ({1'b0, in_coord_y} >= size_y) ||
                     ({1'b0, in_coord_z} >= size_z);
    end

    // result payload
    if (commit) begin
      out_status_r <= res_status;
      out_code_r   <= res_code;
      out_cond_r   <= res_cond;
      out_cnt_r    <= cnt_nxt;
      out_fluid_r  <= CNT_W'(cnt_nxt.plain + cnt_nxt.slot);
      out_table_r  <= alloc_nxt;
      out_free_r   <= depth_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_cell_code         = out_code_r;
  assign out_cell_cond         = out_cond_r;
  assign out_solid_total       = out_cnt_r.solid;
  assign out_fluid_total       = out_fluid_r;
  assign out_plain_fluid_total = out_cnt_r.plain;
  assign out_slot_cell_total   = out_cnt_r.slot;
  assign out_undefined_total   = out_cnt_r.undef;
  assign out_table_size        = out_table_r;
  assign out_free_slots        = out_free_r;

endmodule

`default_nettype wire

// ===== src/ctsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ctsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/ctsa_cfg.sv =====
// Grid size registers behind the APB-style port.
// Depends on ctsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctsa_cfg
  import ctsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output logic      [SIZE_W-1:0] size_x,
  output logic      [SIZE_W-1:0] size_y,
  output logic      [SIZE_W-1:0] size_z
);

  localparam logic [SIZE_W-1:0] AXIS_MAX = SIZE_W'(1 << AXIS_BITS);

  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [SIZE_W-1:0] wval;
  logic              wr;
  reg_idx_t          idx;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr     = psel && penable && pwrite && pready;
  // only the low six bits of pwdata count; values above the grid edge act as the edge
  assign wval   = (pwdata[SIZE_W-1:0] > AXIS_MAX) ? AXIS_MAX : pwdata[SIZE_W-1:0];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= AXIS_MAX;
      size_y_r <= AXIS_MAX;
      size_z_r <= AXIS_MAX;
    end else if (wr) begin
      case (idx)
        REG_SIZE_X: size_x_r <= wval;
        REG_SIZE_Y: size_y_r <= wval;
        REG_SIZE_Z: size_z_r <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SIZE_X: prdata = CFG_DW'(size_x_r);
      REG_SIZE_Y: prdata = CFG_DW'(size_y_r);
      REG_SIZE_Z: prdata = CFG_DW'(size_z_r);
      default:    prdata = '0;
    endcase
  end

  assign size_x = size_x_r;
  assign size_y = size_y_r;
  assign size_z = size_z_r;

endmodule

`default_nettype wire

// ===== src/ctsa_stats.sv =====
// Running per-class cell counters.
// Depends on ctsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctsa_stats
  import ctsa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cnt_upd_t upd,
  output cnt_set_t      cnt_nxt
);

  cnt_set_t cnt_r;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c,
                                            input logic inc, input logic dec);
    return CNT_W'(c + {{(CNT_W-1){1'b0}}, inc} - {{(CNT_W-1){1'b0}}, dec});
  endfunction

  always_comb begin
    cnt_nxt = cnt_r;
    if (upd.en) begin
      cnt_nxt.solid = bump(cnt_r.solid, upd.new_cls == CLS_SOLID, upd.old_cls == CLS_SOLID);
      cnt_nxt.plain = bump(cnt_r.plain, upd.new_cls == CLS_FLUID, upd.old_cls == CLS_FLUID);
      cnt_nxt.iface = bump(cnt_r.iface, upd.new_cls == CLS_IFACE, upd.old_cls == CLS_IFACE);
      cnt_nxt.slot  = bump(cnt_r.slot,  upd.new_cls == CLS_SLOT,  upd.old_cls == CLS_SLOT);
      cnt_nxt.undef = bump(cnt_r.undef, upd.new_cls == CLS_UNDEF, upd.old_cls == CLS_UNDEF);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      cnt_r.undef <= CNT_W'(GRID_CELLS);
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/ctsa_chk.sv =====
// Port-level checker for the cell type map unit, bound to the top level.
// Depends on ctsa_pkg and the unit's assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "cell_type_map_with_slot_allocator_unit_defines.svh"

module ctsa_chk
  import ctsa_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [1:0]             out_status,
  input wire logic [CODE_W-1:0]      out_cell_code,
  input wire logic [HANDLE_BITS-1:0] out_cell_cond,
  input wire logic [TBL_W-1:0]       out_table_size,
  input wire logic [TBL_W-1:0]       out_free_slots
);

  localparam logic [TBL_W-1:0] SLOTS_MAX = TBL_W'(SLOT_COUNT);

  // one word in flight: ready drops right after an accept
  `CTSA_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "ready after accept")

  // a held result word keeps its cell code and status
  `CTSA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_cell_code) && $stable(out_status), "result changed while stalled")

  // rejected coordinates report an empty cell
  `CTSA_ASSERT_IMP(a_range_empty, out_valid && out_status == ST_RANGE, out_cell_code == '0 && out_cell_cond == '0, "range reject shows content")

  // table size stays within the slot count, free stack never holds more than the table gave out
  `CTSA_ASSERT_IMP(a_alloc_bounds, out_valid, out_table_size <= SLOTS_MAX && out_free_slots <= out_table_size, "allocator counts out of bounds")

  // table full is only reported with nothing left to hand out
  `CTSA_ASSERT_IMP(a_full_state, out_valid && out_status == ST_FULL, out_free_slots == '0 && out_table_size == SLOTS_MAX, "table full with slots left")

endmodule

bind cell_type_map_with_slot_allocator_unit ctsa_chk u_ctsa_chk (.*);

`default_nettype wire
